>>> hw/rtl/ilm_pkg.sv
// ----------------------------------------------------------------------------
// ilm_pkg
// Shared codes, widths and the walking transaction token of the linked list
// manager.
// ----------------------------------------------------------------------------
package ilm_pkg;

    localparam int VALUE_W    = 32;
    localparam int REQ_W      = 3;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SORTED_INS = 3'd4;
    localparam logic [REQ_W-1:0] REQ_REMOVE     = 3'd5;
    localparam logic [REQ_W-1:0] REQ_SEARCH     = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNUSED     = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_REMOVE,
        OP_SEARCH
    } op_kind_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_FREE,
        COND_ORDER,
        COND_LAST,
        COND_MATCH
    } cond_t;

    typedef struct packed {
        logic                active;
        op_kind_t            kind;
        cond_t               cond;
        logic                done;
        logic                carry_valid;
        logic [VALUE_W-1:0]  carry_value;
        logic [VALUE_W-1:0]  operand;
    } tok_t;

endpackage

>>> hw/rtl/ilm_cell.sv
// ----------------------------------------------------------------------------
// ilm_cell
// One list position: holds an entry and acts on the token passing through.
// ----------------------------------------------------------------------------
module ilm_cell
    import ilm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  tok_t               tok_in,
    input  logic               nxt_valid,
    input  logic [VALUE_W-1:0] nxt_value,
    output logic               valid,
    output logic [VALUE_W-1:0] value,
    output tok_t               tok_out
);

    logic               valid_reg;
    logic               valid_next;
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    tok_t               tok_reg;
    tok_t               tok_next;
    logic               cond_ok;
    logic               hit;

    always_comb
    begin
        case (tok_in.cond)
            COND_ALWAYS: cond_ok = 1'b1;
            COND_FREE:   cond_ok = !valid_reg;
            COND_ORDER:  cond_ok = !valid_reg ||
                                   ($signed(value_reg) > $signed(tok_in.operand));
            COND_LAST:   cond_ok = valid_reg && !nxt_valid;
            COND_MATCH:  cond_ok = valid_reg && (value_reg == tok_in.operand);
            default:     cond_ok = 1'b0;
        endcase
    end

    assign hit = tok_in.active && !tok_in.done && cond_ok;

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        tok_next   = tok_in;
        if (tok_in.active)
        begin
            case (tok_in.kind)
                OP_INSERT:
                begin
                    if (tok_in.done || hit)
                    begin
                        valid_next           = tok_in.done ? tok_in.carry_valid : 1'b1;
                        value_next           = tok_in.done ? tok_in.carry_value
                                                           : tok_in.operand;
                        tok_next.carry_valid = valid_reg;
                        tok_next.carry_value = value_reg;
                        tok_next.done        = 1'b1;
                    end
                end
                OP_REMOVE:
                begin
                    if (tok_in.done || hit)
                    begin
                        valid_next = nxt_valid;
                        value_next = nxt_value;
                    end
                    if (hit)
                    begin
                        tok_next.done        = 1'b1;
                        tok_next.carry_value = value_reg;
                    end
                end
                OP_SEARCH:
                begin
                    if (hit)
                    begin
                        tok_next.done = 1'b1;
                    end
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign valid   = valid_reg;
    assign value   = value_reg;
    assign tok_out = tok_reg;

endmodule

>>> hw/rtl/indexed_linked_list_manager.sv
// ----------------------------------------------------------------------------
// indexed_linked_list_manager
// Ordered list of up to CAPACITY signed values held in a row of cells.
// ----------------------------------------------------------------------------
// Requests arrive on the s_ group (req_type, operand_value) and each one
// gives exactly one response transaction on the m_ group (status,
// popped_value). Position 0 of the cell row is the head of the list.
// A request that the list state settles at once (full pool, empty list,
// unused code) answers in the cycle after it is accepted. Every other
// request sends a token through the row of cells, one cell per cycle, from
// the launch register through each cell's token register; the response is
// registered when the token leaves the last cell. One request is in flight
// at a time: no request is accepted while a token walks the row.
// A new request is accepted while a response is being taken. After reset
// the list is empty and s_tready is high. When the receiver stalls, the
// response is held in the output register and no further request is
// accepted until it has been taken.
// ----------------------------------------------------------------------------
module indexed_linked_list_manager
    import ilm_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // Fields from bit 0: req_type[2:0], operand_value[34:3], zero padding.
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // Fields from bit 0: status[1:0], popped_value[33:2], zero padding.
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic [REQ_W-1:0]    req_type;
    logic [VALUE_W-1:0]  operand_value;
    logic                in_accept;

    logic                cell_valid [CAPACITY];
    logic [VALUE_W-1:0]  cell_value [CAPACITY];
    tok_t                tok_chain  [CAPACITY+1];

    tok_t                launch_reg;
    tok_t                launch_next;
    logic                busy_reg;
    logic                busy_next;
    logic [REQ_W-1:0]    req_reg;
    logic [REQ_W-1:0]    req_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [VALUE_W-1:0]  popped_reg;
    logic [VALUE_W-1:0]  popped_next;
    tok_t                tok_exit;

    assign req_type      = s_tdata[REQ_W-1:0];
    assign operand_value = s_tdata[REQ_W+VALUE_W-1:REQ_W];
    assign s_tready      = !busy_reg && (!out_valid_reg || m_tready);
    assign in_accept     = s_tvalid && s_tready;
    assign tok_chain[0]  = launch_reg;
    assign tok_exit      = tok_chain[CAPACITY];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic               nv;
            logic [VALUE_W-1:0] nval;
            if (gi == CAPACITY - 1)
            begin : g_tail
                assign nv   = 1'b0;
                assign nval = '0;
            end
            else
            begin : g_inner
                assign nv   = cell_valid[gi+1];
                assign nval = cell_value[gi+1];
            end
            ilm_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .tok_in    (tok_chain[gi]),
                .nxt_valid (nv),
                .nxt_value (nval),
                .valid     (cell_valid[gi]),
                .value     (cell_value[gi]),
                .tok_out   (tok_chain[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        launch_next        = '0;
        launch_next.kind   = OP_SEARCH;
        launch_next.cond   = COND_ALWAYS;
        busy_next          = busy_reg;
        req_next           = req_reg;
        out_valid_next     = out_valid_reg && !m_tready;
        status_next        = status_reg;
        popped_next        = popped_reg;

        if (in_accept)
        begin
            req_next             = req_type;
            launch_next.operand  = operand_value;
            case (req_type)
                REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_SORTED_INS:
                begin
                    if (cell_valid[CAPACITY-1])
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_FULL;
                        popped_next    = '0;
                    end
                    else
                    begin
                        busy_next          = 1'b1;
                        launch_next.active = 1'b1;
                        launch_next.kind   = OP_INSERT;
                        if (req_type == REQ_PUSH_FRONT)
                        begin
                            launch_next.cond = COND_ALWAYS;
                        end
                        else if (req_type == REQ_PUSH_BACK)
                        begin
                            launch_next.cond = COND_FREE;
                        end
                        else
                        begin
                            launch_next.cond = COND_ORDER;
                        end
                    end
                end
                REQ_POP_FRONT, REQ_POP_BACK, REQ_REMOVE, REQ_SEARCH:
                begin
                    if (!cell_valid[0])
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_EMPTY;
                        popped_next    = '0;
                    end
                    else
                    begin
                        busy_next          = 1'b1;
                        launch_next.active = 1'b1;
                        if (req_type == REQ_SEARCH)
                        begin
                            launch_next.kind = OP_SEARCH;
                        end
                        else
                        begin
                            launch_next.kind = OP_REMOVE;
                        end
                        if (req_type == REQ_POP_FRONT)
                        begin
                            launch_next.cond = COND_ALWAYS;
                        end
                        else if (req_type == REQ_POP_BACK)
                        begin
                            launch_next.cond = COND_LAST;
                        end
                        else
                        begin
                            launch_next.cond = COND_MATCH;
                        end
                    end
                end
                default:
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    popped_next    = '0;
                end
            endcase
        end
        else if (busy_reg && tok_exit.active)
        begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
            popped_next    = '0;
            status_next    = ST_OK;
            if ((tok_exit.kind != OP_INSERT) && !tok_exit.done)
            begin
                status_next = ST_NOT_FOUND;
            end
            if ((req_reg == REQ_POP_FRONT) || (req_reg == REQ_POP_BACK))
            begin
                popped_next = tok_exit.carry_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launch_reg    <= '0;
            busy_reg      <= 1'b0;
            req_reg       <= REQ_UNUSED;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            popped_reg    <= '0;
        end
        else
        begin
            launch_reg    <= launch_next;
            busy_reg      <= busy_next;
            req_reg       <= req_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            popped_reg    <= popped_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-STATUS_W-VALUE_W){1'b0}}, popped_reg, status_reg};

endmodule

>>> verif/tb_indexed_linked_list_manager.sv
// ----------------------------------------------------------------------------
// tb_indexed_linked_list_manager
// Self-checking testbench for the indexed linked list manager.
// ----------------------------------------------------------------------------
// A short table of directed requests walks through the empty list, the
// unused request code, the signed extremes, sorted insertion around the head
// and tail with equal values, and removal with duplicates. Random requests
// follow in phases that favour growing the list, shrinking it or churning it.
// The operands of searches and removals often come from values held in the
// list. A behavioural model of the pool predicts every response that the table
// does not pin, and each response transaction is compared with the oldest
// prediction. Both sides idle in short random bursts, except near the end.
// ----------------------------------------------------------------------------
module tb_indexed_linked_list_manager;
    import ilm_pkg::*;

    localparam int CAP        = 16;
    localparam int RAND_ITEMS = 925;
    localparam int CALM_ITEMS = 150;
    localparam int ROWS       = 23;

    typedef enum int {
        GROW,
        SHRINK,
        CHURN
    } phase_t;

    typedef struct packed {
        logic [REQ_W-1:0]    rq;
        logic [VALUE_W-1:0]  v;
        logic                pinned;
        logic [STATUS_W-1:0] st;
        logic [VALUE_W-1:0]  pop;
    } row_t;

    typedef struct packed {
        logic                pinned;
        logic [STATUS_W-1:0] st;
        logic [VALUE_W-1:0]  pop;
    } pin_t;

    typedef struct packed {
        logic [STATUS_W-1:0] st;
        logic [VALUE_W-1:0]  pop;
    } reply_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b1;
    logic [M_TDATA_W-1:0] m_tdata;

    logic [VALUE_W-1:0] val_mem [CAP];
    int                 link_mem [CAP];
    int                 list_head;
    int                 free_head;

    pin_t   pin_q[$];
    reply_t reply_q[$];
    int     err_count = 0;
    bit     idle_on   = 1'b1;
    int     stall_left = 0;

    row_t dir_rows [ROWS] = '{
        '{REQ_POP_FRONT,  32'h0000_0000, 1'b1, ST_EMPTY,     32'h0},
        '{REQ_POP_BACK,   32'hFFFF_FFFF, 1'b1, ST_EMPTY,     32'h0},
        '{REQ_REMOVE,     32'h0000_0005, 1'b1, ST_EMPTY,     32'h0},
        '{REQ_SEARCH,     32'h0000_0005, 1'b1, ST_EMPTY,     32'h0},
        '{REQ_UNUSED,     32'hFFFF_FFFF, 1'b1, ST_OK,        32'h0},
        '{REQ_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, ST_OK,        32'h0},
        '{REQ_SORTED_INS, 32'h8000_0000, 1'b1, ST_OK,        32'h0},
        '{REQ_SORTED_INS, 32'h0000_0000, 1'b0, ST_OK,        32'h0},
        '{REQ_SORTED_INS, 32'h0000_0000, 1'b0, ST_OK,        32'h0},
        '{REQ_SORTED_INS, 32'h7FFF_FFFF, 1'b0, ST_OK,        32'h0},
        '{REQ_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, ST_OK,        32'h0},
        '{REQ_SEARCH,     32'h0000_0000, 1'b0, ST_OK,        32'h0},
        '{REQ_SEARCH,     32'h0000_0007, 1'b1, ST_NOT_FOUND, 32'h0},
        '{REQ_REMOVE,     32'h0000_0000, 1'b0, ST_OK,        32'h0},
        '{REQ_SEARCH,     32'h0000_0000, 1'b0, ST_OK,        32'h0},
        '{REQ_REMOVE,     32'h7FFF_FFFF, 1'b0, ST_OK,        32'h0},
        '{REQ_POP_BACK,   32'h0000_0000, 1'b0, ST_OK,        32'h0},
        '{REQ_POP_FRONT,  32'h0000_0000, 1'b0, ST_OK,        32'h0},
        '{REQ_SORTED_INS, 32'h0000_0005, 1'b0, ST_OK,        32'h0},
        '{REQ_POP_FRONT,  32'h0000_0000, 1'b0, ST_OK,        32'h0},
        '{REQ_POP_BACK,   32'h0000_0000, 1'b0, ST_OK,        32'h0},
        '{REQ_POP_BACK,   32'h0000_0000, 1'b0, ST_OK,        32'h0},
        '{REQ_SEARCH,     32'h0000_0000, 1'b1, ST_EMPTY,     32'h0}
    };

    indexed_linked_list_manager #(
        .CAPACITY(CAP)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void clear_pool();
        for (int i = 0; i < CAP; i++)
        begin
            val_mem[i]  = '0;
            link_mem[i] = i + 1;
        end
        list_head = CAP;
        free_head = 0;
    endfunction

    function automatic int take_entry();
        int n;
        n         = free_head;
        free_head = link_mem[n];
        return n;
    endfunction

    function automatic void give_entry(input int n);
        link_mem[n] = free_head;
        free_head   = n;
    endfunction

    function automatic void apply_request(input logic [REQ_W-1:0] rq,
                                          input logic [VALUE_W-1:0] v,
                                          output logic [STATUS_W-1:0] st,
                                          output logic [VALUE_W-1:0] pop);
        int prev;
        int cur;
        int n;
        int steps;
        st    = ST_OK;
        pop   = '0;
        prev  = CAP;
        cur   = list_head;
        steps = 0;
        if (rq == REQ_PUSH_FRONT || rq == REQ_PUSH_BACK || rq == REQ_SORTED_INS)
        begin
            if (free_head >= CAP)
                st = ST_FULL;
            else if (rq == REQ_PUSH_FRONT)
            begin
                n           = take_entry();
                val_mem[n]  = v;
                link_mem[n] = list_head;
                list_head   = n;
            end
            else if (rq == REQ_PUSH_BACK)
            begin
                n           = take_entry();
                val_mem[n]  = v;
                link_mem[n] = CAP;
                if (list_head >= CAP)
                    list_head = n;
                else
                begin
                    while (link_mem[cur] < CAP && steps < CAP)
                    begin
                        cur = link_mem[cur];
                        steps++;
                    end
                    link_mem[cur] = n;
                end
            end
            else
            begin
                while (cur < CAP && steps < CAP && $signed(val_mem[cur]) <= $signed(v))
                begin
                    prev = cur;
                    cur  = link_mem[cur];
                    steps++;
                end
                n           = take_entry();
                val_mem[n]  = v;
                link_mem[n] = cur;
                if (prev >= CAP)
                    list_head = n;
                else
                    link_mem[prev] = n;
            end
        end
        else if (rq >= REQ_POP_FRONT && rq <= REQ_SEARCH)
        begin
            if (list_head >= CAP)
                st = ST_EMPTY;
            else if (rq == REQ_POP_FRONT)
            begin
                pop       = val_mem[cur];
                list_head = link_mem[cur];
                give_entry(cur);
            end
            else if (rq == REQ_POP_BACK)
            begin
                while (link_mem[cur] < CAP && steps < CAP)
                begin
                    prev = cur;
                    cur  = link_mem[cur];
                    steps++;
                end
                pop = val_mem[cur];
                if (prev >= CAP)
                    list_head = CAP;
                else
                    link_mem[prev] = CAP;
                give_entry(cur);
            end
            else
            begin
                while (cur < CAP && steps < CAP && val_mem[cur] != v)
                begin
                    prev = cur;
                    cur  = link_mem[cur];
                    steps++;
                end
                if (cur >= CAP)
                    st = ST_NOT_FOUND;
                else if (rq == REQ_REMOVE)
                begin
                    if (prev >= CAP)
                        list_head = link_mem[cur];
                    else
                        link_mem[prev] = link_mem[cur];
                    give_entry(cur);
                end
            end
        end
    endfunction

    function automatic logic [REQ_W-1:0] pick_request(input phase_t ph);
        int r;
        int grow_pct;
        r        = $urandom_range(0, 99);
        grow_pct = (ph == GROW) ? 70 : (ph == SHRINK) ? 20 : 45;
        if (r == 0)
            return REQ_UNUSED;
        if (r <= grow_pct)
        begin
            case ($urandom_range(0, 2))
                0:       return REQ_PUSH_FRONT;
                1:       return REQ_PUSH_BACK;
                default: return REQ_SORTED_INS;
            endcase
        end
        case ($urandom_range(0, 3))
            0:       return REQ_POP_FRONT;
            1:       return REQ_POP_BACK;
            2:       return REQ_REMOVE;
            default: return REQ_SEARCH;
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] pick_operand(input logic [REQ_W-1:0] rq);
        int cur;
        int hops;
        if ((rq == REQ_REMOVE || rq == REQ_SEARCH) && list_head < CAP
            && $urandom_range(0, 1) == 1)
        begin
            cur  = list_head;
            hops = $urandom_range(0, CAP - 1);
            while (hops > 0 && link_mem[cur] < CAP)
            begin
                cur = link_mem[cur];
                hops--;
            end
            return val_mem[cur];
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return $unsigned(32'($signed($urandom_range(0, 8)) - 4));
            6:                return ($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            7:                return 32'h1 << $urandom_range(0, 31);
            default:          return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] exp_v,
                                   input logic [VALUE_W-1:0] act_v);
        err_count++;
        if (err_count <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_v, act_v);
    endtask

    task automatic issue(input logic [REQ_W-1:0] rq, input logic [VALUE_W-1:0] v,
                         input pin_t pin);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        pin_q.push_back(pin);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - VALUE_W - REQ_W){1'b0}}, v, rq};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n || !idle_on)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin : watch
        reply_t want;
        pin_t   pin;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (reply_q.size() == 0)
                    report_mismatch("unexpected response", '0, m_tdata[VALUE_W+1:2]);
                else
                begin
                    want = reply_q.pop_front();
                    if (m_tdata[1:0] !== want.st)
                        report_mismatch("status", VALUE_W'(want.st), VALUE_W'(m_tdata[1:0]));
                    if (m_tdata[VALUE_W+1:2] !== want.pop)
                        report_mismatch("popped value", want.pop, m_tdata[VALUE_W+1:2]);
                end
            end
            if (s_tvalid && s_tready)
            begin
                pin = pin_q.pop_front();
                apply_request(s_tdata[REQ_W-1:0], s_tdata[VALUE_W+REQ_W-1:REQ_W],
                              want.st, want.pop);
                if (pin.pinned)
                begin
                    want.st  = pin.st;
                    want.pop = pin.pop;
                end
                reply_q.push_back(want);
            end
        end
    end

    initial
    begin
        phase_t           ph;
        logic [REQ_W-1:0] rq;
        int               sent;
        int               run_len;
        clear_pool();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < ROWS; i++)
            issue(dir_rows[i].rq, dir_rows[i].v,
                  '{dir_rows[i].pinned, dir_rows[i].st, dir_rows[i].pop});

        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            ph      = phase_t'($urandom_range(0, 2));
            run_len = $urandom_range(20, 40);
            for (int j = 0; j < run_len && sent < RAND_ITEMS; j++)
            begin
                if (sent >= RAND_ITEMS - CALM_ITEMS)
                    idle_on = 1'b0;
                rq = pick_request(ph);
                issue(rq, pick_operand(rq), '0);
                sent++;
            end
        end
        s_tvalid <= 1'b0;

        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (CAP + 4) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/ilm_pkg.sv
hw/rtl/ilm_cell.sv
hw/rtl/indexed_linked_list_manager.sv
verif/tb_indexed_linked_list_manager.sv
